// ===== sv/bfm_pkg.sv =====
// shared types, constants and helpers for the bloom filter membership block
`default_nettype none

package bfm_pkg;

   // array geometry
   localparam int MAX_BITS   = 65536;
   localparam int MAX_HASHES = 16;
   localparam int HASH_W     = 64;
   localparam int MOD_W      = $clog2(MAX_BITS + 1);
   localparam int BIT_POS_W  = $clog2(MAX_BITS);
   localparam int ROW_W      = 64;
   localparam int ROW_SEL_W  = $clog2(ROW_W);
   localparam int ROWS       = MAX_BITS / ROW_W;
   localparam int ROW_ADDR_W = BIT_POS_W - ROW_SEL_W;
   localparam int STEP_CNT_W = $clog2(HASH_W);

   // group bookkeeping
   localparam int GRP_W      = $clog2(MAX_HASHES + 1);
   localparam int GPOS_W     = $clog2(MAX_HASHES);

   // counts and configuration
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = MOD_W;
   localparam int HASH_CFG_W = 5;

   localparam logic [MOD_W-1:0]      NUM_BITS_RESET   = MOD_W'(65536);
   localparam logic [HASH_CFG_W-1:0] NUM_HASHES_RESET = HASH_CFG_W'(7);

   // operation codes
   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_QUERY  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BITS   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_HASHES = CSR_IDX_W'(1);

   typedef struct packed {
      logic [1:0]        func;
      logic [HASH_W-1:0] hash_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         done_op;
      logic               present;
      logic [COUNT_W-1:0] elements_added;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_MODIFY,
      ST_EMIT
   } state_type;

   // modulus in use: zero acts as one, large values clip to the array size
   function automatic logic [MOD_W-1:0] clamp_modulus(input logic [MOD_W-1:0] v);
      logic [MOD_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = MOD_W'(1);
      end else if (v > MOD_W'(MAX_BITS)) begin
         r = MOD_W'(MAX_BITS);
      end
      return r;
   endfunction

   // group size in use: zero acts as one, large values clip to the maximum
   function automatic logic [GRP_W-1:0] clamp_group(input logic [HASH_CFG_W-1:0] v);
      logic [GRP_W-1:0] r;
      r = GRP_W'(v);
      if (v == '0) begin
         r = GRP_W'(1);
      end else if (HASH_CFG_W'(v) > HASH_CFG_W'(MAX_HASHES)) begin
         r = GRP_W'(MAX_HASHES);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/bloom_filter_membership_top.sv =====
// top level of the bloom filter membership block: control, bit array and ports
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   req     | in        | req_valid/req_stall| func, hash_value
//   rsp     | out       | rsp_valid/rsp_stall| done_op, present, elements_added
//   csr     | in        | csr_valid/csr_ready| csr_index, csr_wdata
//
// an add or query item is accepted, then runs through the bit-serial remainder
//   unit (one hash bit per cycle); the array row is then read and, for an add,
//   written back; a group's last item then loads the result
// a clear item, and reset, start a clearing pass over all 1024 rows (one 64-bit
//   row per cycle) during which no item is accepted; config writes still land
// an unused code at the start of a group is dropped in its accept cycle
// a stalled result holds the block only at the point where the next result
//   would have to be loaded

`default_nettype none

module bloom_filter_membership_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bfm_pkg::req_type                  req_data,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bfm_pkg::rsp_type                       rsp_data,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // control state
   bfm_pkg::state_type                    state_ff, state_in;
   logic [bfm_pkg::ROW_ADDR_W-1:0]        sweep_ff, sweep_in;
   logic                                  clr_emit_ff, clr_emit_in;
   logic [bfm_pkg::GPOS_W-1:0]            pos_ff, pos_in;
   logic                                  op_ff, op_in;
   logic                                  all_set_ff, all_set_in;
   logic [bfm_pkg::COUNT_W-1:0]           count_ff, count_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [bfm_pkg::MOD_W-1:0]             num_bits_ff, num_bits_in;
   logic [bfm_pkg::HASH_CFG_W-1:0]        num_hashes_ff, num_hashes_in;

   // result staging, no reset needed
   logic [1:0]                            emit_op_ff, emit_op_in;
   logic                                  emit_present_ff, emit_present_in;
   bfm_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   // bit array: 1024 rows of 64 bits, one write and one registered read port
   logic [bfm_pkg::ROW_W-1:0]             mem_array [bfm_pkg::ROWS];
   logic [bfm_pkg::ROW_W-1:0]             rd_row_ff;
   logic                                  mem_we;
   logic [bfm_pkg::ROW_ADDR_W-1:0]        mem_wa;
   logic [bfm_pkg::ROW_W-1:0]             mem_wd;
   logic                                  mem_re;

   // remainder unit
   logic                                  rem_start;
   logic                                  rem_busy;
   logic [bfm_pkg::BIT_POS_W-1:0]         rem_value;
   logic [bfm_pkg::MOD_W-1:0]             modulus;
   logic [bfm_pkg::GRP_W-1:0]             group_size;

   // helpers
   logic [bfm_pkg::ROW_ADDR_W-1:0]        rem_row;
   logic [bfm_pkg::ROW_SEL_W-1:0]         rem_sel;
   logic [bfm_pkg::ROW_W-1:0]             bit_mask;
   logic                                  bit_hit;
   logic                                  all_set_new;
   logic [bfm_pkg::GRP_W-1:0]             pos_next;
   logic                                  slot_free;
   logic                                  accept;

   assign modulus    = bfm_pkg::clamp_modulus(num_bits_ff);
   assign group_size = bfm_pkg::clamp_group(num_hashes_ff);

   assign rem_row  = rem_value[bfm_pkg::BIT_POS_W-1:bfm_pkg::ROW_SEL_W];
   assign rem_sel  = rem_value[bfm_pkg::ROW_SEL_W-1:0];
   assign bit_mask = bfm_pkg::ROW_W'(1) << rem_sel;
   assign bit_hit  = rd_row_ff[rem_sel];
   assign all_set_new = all_set_ff & bit_hit;
   assign pos_next = bfm_pkg::GRP_W'(pos_ff) + bfm_pkg::GRP_W'(1);

   // output register can take a new result when empty or being drained
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != bfm_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   bfm_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_data.hash_value),
      .modulus   (modulus),
      .busy      (rem_busy),
      .remainder (rem_value)
   );

   // configuration port, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      num_bits_in   = num_bits_ff;
      num_hashes_in = num_hashes_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bfm_pkg::CSR_NUM_BITS: begin
               num_bits_in = csr_wdata[bfm_pkg::MOD_W-1:0];
            end
            bfm_pkg::CSR_NUM_HASHES: begin
               num_hashes_in = csr_wdata[bfm_pkg::HASH_CFG_W-1:0];
            end
            default: begin
               // writes to other indexes are dropped
            end
         endcase
      end
   end

   // sequencer: next state, group bookkeeping and array port control
   always_comb begin
      state_in        = state_ff;
      sweep_in        = sweep_ff;
      clr_emit_in     = clr_emit_ff;
      pos_in          = pos_ff;
      op_in           = op_ff;
      all_set_in      = all_set_ff;
      count_in        = count_ff;
      emit_op_in      = emit_op_ff;
      emit_present_in = emit_present_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      mem_we          = 1'b0;
      mem_wa          = rem_row;
      mem_wd          = rd_row_ff | bit_mask;
      mem_re          = 1'b0;
      rem_start       = 1'b0;

      unique case (state_ff)
         bfm_pkg::ST_CLEAR: begin
            // zero one row per cycle
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = '0;
            sweep_in = sweep_ff + bfm_pkg::ROW_ADDR_W'(1);
            if (sweep_ff == bfm_pkg::ROW_ADDR_W'(bfm_pkg::ROWS - 1)) begin
               state_in = clr_emit_ff ? bfm_pkg::ST_EMIT : bfm_pkg::ST_IDLE;
            end
         end

         bfm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.func == bfm_pkg::FUNC_CLEAR) begin
                  // drop any partial group and restart the array
                  count_in        = '0;
                  pos_in          = '0;
                  op_in           = 1'b0;
                  all_set_in      = 1'b1;
                  clr_emit_in     = 1'b1;
                  sweep_in        = '0;
                  emit_op_in      = bfm_pkg::FUNC_CLEAR;
                  emit_present_in = 1'b0;
                  state_in        = bfm_pkg::ST_CLEAR;
               end else if (pos_ff == '0 && req_data.func == bfm_pkg::FUNC_UNUSED) begin
                  // unused code opening a group: ignored
                  state_in = bfm_pkg::ST_IDLE;
               end else begin
                  if (pos_ff == '0) begin
                     op_in      = req_data.func[0];
                     all_set_in = 1'b1;
                  end
                  rem_start = 1'b1;
                  state_in  = bfm_pkg::ST_DIV;
               end
            end
         end

         bfm_pkg::ST_DIV: begin
            // remainder ready: fetch the row holding the addressed bit
            if (!rem_busy) begin
               mem_re   = 1'b1;
               state_in = bfm_pkg::ST_MODIFY;
            end
         end

         bfm_pkg::ST_MODIFY: begin
            mem_we = !op_ff;
            if (pos_next < group_size) begin
               pos_in     = pos_next[bfm_pkg::GPOS_W-1:0];
               all_set_in = op_ff ? all_set_new : all_set_ff;
               state_in   = bfm_pkg::ST_IDLE;
            end else begin
               // group complete
               pos_in     = '0;
               op_in      = 1'b0;
               all_set_in = 1'b1;
               if (op_ff) begin
                  emit_op_in      = bfm_pkg::FUNC_QUERY;
                  emit_present_in = all_set_new;
               end else begin
                  emit_op_in      = bfm_pkg::FUNC_ADD;
                  emit_present_in = 1'b0;
                  if (count_ff != '1) begin
                     count_in = count_ff + bfm_pkg::COUNT_W'(1);
                  end
               end
               state_in = bfm_pkg::ST_EMIT;
            end
         end

         bfm_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.done_op         = emit_op_ff;
               rsp_data_in.present         = emit_present_ff;
               rsp_data_in.elements_added  = count_ff;
               state_in                    = bfm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bfm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfm_pkg::ST_CLEAR;
         sweep_ff      <= '0;
         clr_emit_ff   <= 1'b0;
         pos_ff        <= '0;
         op_ff         <= 1'b0;
         all_set_ff    <= 1'b1;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         num_bits_ff   <= bfm_pkg::NUM_BITS_RESET;
         num_hashes_ff <= bfm_pkg::NUM_HASHES_RESET;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         clr_emit_ff   <= clr_emit_in;
         pos_ff        <= pos_in;
         op_ff         <= op_in;
         all_set_ff    <= all_set_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         num_bits_ff   <= num_bits_in;
         num_hashes_ff <= num_hashes_in;
      end
      emit_op_ff      <= emit_op_in;
      emit_present_ff <= emit_present_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // bit array ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_row_ff <= mem_array[rem_row];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/bfm_rem.sv =====
// bit-serial remainder of a 64-bit hash by the active modulus
`default_nettype none

module bfm_rem (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [bfm_pkg::HASH_W-1:0]     dividend,
   input  wire logic [bfm_pkg::MOD_W-1:0]      modulus,
   output logic                                busy,
   output logic [bfm_pkg::BIT_POS_W-1:0]       remainder
);

   logic                               run_ff, run_in;
   logic [bfm_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [bfm_pkg::HASH_W-1:0]         hash_ff, hash_in;
   logic [bfm_pkg::BIT_POS_W-1:0]      rem_ff, rem_in;

   logic [bfm_pkg::MOD_W-1:0]          trial;
   logic [bfm_pkg::MOD_W-1:0]          diff;

   // one dividend bit enters the partial remainder each cycle while the unit runs
   assign trial = {rem_ff, hash_ff[bfm_pkg::HASH_W-1]};
   assign diff  = trial - modulus;

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      hash_in = hash_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         hash_in = dividend;
         rem_in  = '0;
      end else if (run_ff) begin
         hash_in = {hash_ff[bfm_pkg::HASH_W-2:0], 1'b0};
         cnt_in  = cnt_ff + bfm_pkg::STEP_CNT_W'(1);
         if (trial >= modulus) begin
            rem_in = diff[bfm_pkg::BIT_POS_W-1:0];
         end else begin
            rem_in = trial[bfm_pkg::BIT_POS_W-1:0];
         end
         if (cnt_ff == '1) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
   end

   assign busy      = run_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/bfm_checker.sv =====
// port-level checks for the bloom filter membership block and their binding
`default_nettype none

module bfm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire bfm_pkg::req_type                  req_data,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire bfm_pkg::rsp_type                  rsp_data
);

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // the array is swept after reset before any item is taken
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("item taken right after reset");

   // an accepted clear blocks the input while the array is swept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.func == bfm_pkg::FUNC_CLEAR |=> req_stall)
      else $error("input open right after a clear");

   // a clear result reports an empty filter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_op == bfm_pkg::FUNC_CLEAR
         |-> rsp_data.elements_added == '0 && !rsp_data.present)
      else $error("clear result not empty");

   // only a query may report present
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.present |-> rsp_data.done_op == bfm_pkg::FUNC_QUERY)
      else $error("present set on a non-query result");

endmodule

bind bloom_filter_membership_top bfm_checker u_bfm_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the bloom filter membership block
import bfm_pkg::*;

class bloom_scoreboard;
   bit                    filter_bits[MAX_BITS];
   logic [COUNT_W-1:0]    add_total;
   int unsigned           group_fill;
   logic [1:0]            group_func;
   bit                    group_hit;
   logic [MOD_W-1:0]      modulus_reg;
   logic [HASH_CFG_W-1:0] group_size_reg;
   rsp_type               awaited_results[$];
   int unsigned           failures;

   function new();
      wipe_filter();
      modulus_reg    = NUM_BITS_RESET;
      group_size_reg = NUM_HASHES_RESET;
      failures       = 0;
   endfunction

   function void restart_group();
      group_fill = 0;
      group_func = FUNC_ADD;
      group_hit  = 1'b1;
   endfunction

   function void wipe_filter();
      foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      add_total = '0;
      restart_group();
   endfunction

   function void set_register(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_NUM_BITS) begin
         modulus_reg = data;
      end else if (idx == CSR_NUM_HASHES) begin
         group_size_reg = data[HASH_CFG_W-1:0];
      end
   endfunction

   // work out the effect of one accepted item and queue its result, if any
   function void apply_item(input req_type item);
      rsp_type          res;
      logic [63:0]      modulus;
      logic [63:0]      pos;
      int unsigned      group_len;
      modulus = 64'(modulus_reg);
      if (modulus == 0) modulus = 1;
      if (modulus > MAX_BITS) modulus = MAX_BITS;
      group_len = group_size_reg;
      if (group_len == 0) group_len = 1;
      if (group_len > MAX_HASHES) group_len = MAX_HASHES;
      res = '0;

      if (item.func == FUNC_CLEAR) begin
         wipe_filter();
         res.done_op = FUNC_CLEAR;
         awaited_results.push_back(res);
         return;
      end
      if (group_fill == 0) begin
         if (item.func == FUNC_UNUSED) return;
         group_func = item.func;
         group_hit  = 1'b1;
      end

      pos = item.hash_value % modulus;
      if (group_func == FUNC_ADD) begin
         filter_bits[pos[BIT_POS_W-1:0]] = 1'b1;
      end else if (!filter_bits[pos[BIT_POS_W-1:0]]) begin
         group_hit = 1'b0;
      end

      group_fill++;
      if (group_fill < group_len) return;

      if (group_func == FUNC_ADD) begin
         if (add_total != '1) add_total++;
         res.done_op = FUNC_ADD;
      end else begin
         res.done_op = FUNC_QUERY;
         res.present = group_hit;
      end
      res.elements_added = add_total;
      awaited_results.push_back(res);
      restart_group();
   endfunction

   function void check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $error("unexpected result: done_op %0d present %0d elements_added %0d",
                got.done_op, got.present, got.elements_added);
         failures++;
         return;
      end
      want = awaited_results.pop_front();
      if (got.done_op !== want.done_op) begin
         $error("done_op: expected %0d, got %0d", want.done_op, got.done_op);
         failures++;
      end
      if (got.present !== want.present) begin
         $error("present: expected %0d, got %0d", want.present, got.present);
         failures++;
      end
      if (got.elements_added !== want.elements_added) begin
         $error("elements_added: expected %0d, got %0d",
                want.elements_added, got.elements_added);
         failures++;
      end
   endfunction

   function int unsigned pending();
      return awaited_results.size();
   endfunction
endclass

module testbench;

   // run sizing
   localparam int unsigned CYCLE_LIMIT   = 1_500_000;
   localparam int unsigned SETTLE_CYCLES = 80;   // one add/query item plus margin
   localparam int unsigned NUM_PHASES    = 8;
   localparam int unsigned PHASE_ITEMS   = 166;
   localparam int unsigned POOL_DEPTH    = 256;
   localparam int unsigned LONG_HOLD     = 800;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bloom_scoreboard sb;

   // idling knobs, percent of cycles
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   int unsigned cycles_run   = 0;

   // generator view of the configuration and hashes known to be in the filter
   int unsigned gen_bits   = 65536;
   int unsigned gen_hashes = 7;
   logic [63:0] added_hashes[$];
   int unsigned items_sent = 0;

   // idle mode per phase: none, sender only, receiver only, both
   int unsigned sender_idle_of_mode[4]   = '{0, 59, 0, 31};
   int unsigned receiver_stall_of_mode[4] = '{0, 0, 59, 31};

   // per-phase register settings, extremes and out-of-range codes included
   int unsigned bits_of_phase[NUM_PHASES]   = '{65536, 1, 64, 65535, 0, 131071, 8, 1000};
   int unsigned hashes_of_phase[NUM_PHASES] = '{7, 16, 3, 2, 1, 31, 0, 5};

   bloom_filter_membership_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // observe every handshake at the rising edge; results first, since a result
   // can never come from the item accepted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.apply_item(req_data);
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_wdata);
      end
   end

   // result side: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = (receiver_stall_pct != 0) && ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // mostly full-width random hashes, some near zero and some near all ones
   function automatic logic [63:0] random_hash();
      case ($urandom_range(0, 7))
         0:       return 64'($urandom_range(0, 1023));
         1:       return ~64'($urandom_range(0, 1023));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // gap before the next item: short geometric runs, now and then a long one
   function automatic int unsigned sender_gap();
      int unsigned n;
      n = 0;
      if (sender_idle_pct == 0) return 0;
      if ($urandom_range(0, 99) < 4) return $urandom_range(20, 150);
      while (($urandom_range(0, 99) < sender_idle_pct) && (n < 40)) n++;
      return n;
   endfunction

   // all driving tasks start and end just after a falling edge; valid stays
   // high on return so a following item can go back to back
   task automatic send_item(input logic [1:0] func, input logic [63:0] hash);
      int unsigned gap;
      gap = sender_gap();
      repeat (gap) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data.func       = func;
      req_data.hash_value = hash;
      req_valid           = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // wait for every outstanding result, then let an in-flight item finish
   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      req_valid = 1'b0;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_config(input int unsigned bits, input int unsigned hashes);
      wait_idle();
      write_register(CSR_NUM_BITS, bits);
      write_register(CSR_NUM_HASHES, hashes);
      // a new modulus maps old hashes elsewhere, so forget them
      if (bits != gen_bits) added_hashes.delete();
      gen_bits   = bits;
      gen_hashes = hashes;
   endtask

   // one add or query group with random content; sometimes a clear, an unused
   // code up front, stray codes on later items or a clear that breaks the group
   task automatic send_group();
      int unsigned group_len;
      int unsigned pick;
      logic [1:0]  op;
      logic [1:0]  f;
      logic [63:0] h;
      group_len = gen_hashes;
      if (group_len == 0) group_len = 1;
      if (group_len > MAX_HASHES) group_len = MAX_HASHES;

      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         send_item(FUNC_CLEAR, random_hash());
         added_hashes.delete();
         items_sent++;
         return;
      end
      if (pick < 5) send_item(FUNC_UNUSED, random_hash());   // dropped, not counted

      op = ($urandom_range(0, 1) == 0) ? FUNC_ADD : FUNC_QUERY;
      for (int unsigned i = 0; i < group_len; i++) begin
         f = op;
         if (i != 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) begin
               f = FUNC_CLEAR;
            end else if (pick < 13) begin
               case ($urandom_range(0, 2))
                  0:       f = FUNC_ADD;
                  1:       f = FUNC_QUERY;
                  default: f = FUNC_UNUSED;
               endcase
            end
         end
         // queries mostly look up hashes that were added, so hits are common
         if ((op == FUNC_QUERY) && (added_hashes.size() != 0) && ($urandom_range(0, 4) != 0)) begin
            h = added_hashes[$urandom_range(0, added_hashes.size() - 1)];
         end else begin
            h = random_hash();
         end
         send_item(f, h);
         items_sent++;
         if (f == FUNC_CLEAR) begin
            added_hashes.delete();
            return;
         end
         if (op == FUNC_ADD) begin
            added_hashes.push_back(h);
            if (added_hashes.size() > POOL_DEPTH) void'(added_hashes.pop_front());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, no idling
      apply_config(65536, 1);
      send_item(FUNC_ADD, '0);
      send_item(FUNC_ADD, '1);                 // top hash lands on the last bit
      send_item(FUNC_QUERY, '0);               // hit
      send_item(FUNC_QUERY, 64'd1);            // miss
      send_item(FUNC_UNUSED, 64'd5);           // unused code at group start, dropped
      send_item(FUNC_CLEAR, '1);
      send_item(FUNC_QUERY, '1);               // miss after clear, count back to zero

      // later items of a group carry stray codes that must be ignored
      apply_config(65536, 3);
      send_item(FUNC_ADD, 64'd5);
      send_item(FUNC_QUERY, 64'd6);
      send_item(FUNC_UNUSED, 64'd7);
      send_item(FUNC_QUERY, 64'd5);
      send_item(FUNC_ADD, 64'd6);
      send_item(FUNC_UNUSED, 64'd7);           // hit on all three bits

      // clear inside a group drops the partial group
      send_item(FUNC_ADD, 64'd100);
      send_item(FUNC_CLEAR, '0);
      send_item(FUNC_QUERY, 64'd5);
      send_item(FUNC_QUERY, 64'd6);
      send_item(FUNC_QUERY, 64'd7);            // miss

      // group size shrinks below the items already taken
      apply_config(65536, 4);
      send_item(FUNC_ADD, 64'd9);
      send_item(FUNC_ADD, 64'd10);
      apply_config(65536, 1);
      send_item(FUNC_ADD, 64'd11);             // closes the group of three

      // zero codes act as one
      apply_config(0, 0);
      send_item(FUNC_ADD, random_hash());
      send_item(FUNC_QUERY, random_hash());    // single-bit filter, always a hit

      // oversized modulus clips to the array; array kept across the change
      apply_config(131071, 1);
      send_item(FUNC_QUERY, 64'd65547);        // wraps to bit 11, still set

      // random phases over all idle modes and register settings
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         int unsigned bits;
         int unsigned hashes;
         int unsigned phase_start;
         bits   = bits_of_phase[p];
         hashes = hashes_of_phase[p];
         if (p == 3) bits = $urandom_range(2, 65536);
         if (p == 7) hashes = $urandom_range(1, MAX_HASHES);
         apply_config(bits, hashes);
         sender_idle_pct    = sender_idle_of_mode[p % 4];
         receiver_stall_pct = receiver_stall_of_mode[p % 4];

         // one result per item and a long hold-off: the block backs up and
         // stalls its input while items keep being offered
         if (p == 4) hold_request = LONG_HOLD;

         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS / 2) send_group();
         // sender pauses until everything outstanding has come back
         if (p == 5) wait_idle();
         while (items_sent - phase_start < PHASE_ITEMS) send_group();
      end

      wait_idle();
      if ((sb.failures == 0) && (sb.pending() == 0)) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== bloom_filter_membership_top.f =====
sv/bfm_pkg.sv
sv/bfm_rem.sv
sv/bloom_filter_membership_top.sv
sv/bfm_checker.sv
bench/testbench.sv
